/* sv/ufc_pkg.sv */
// Shared types and constants for the UDP flow classifier.
`timescale 1ns / 1ps
package ufc_pkg;
	localparam int TableEntries = 16;
	localparam int IdxW = $clog2(TableEntries);
	localparam int CntW = $clog2(TableEntries + 1);
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;

	typedef enum logic [1:0] {
		REQ_CLASSIFY = 2'd0,
		REQ_ADD = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_DEFAULT = 3'd1,
		ST_DUP = 3'd2,
		ST_FULL = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_NODEFAULT = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [15:0] eth_type;
		logic [7:0] ip_proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] udp_dst_port;
		logic [31:0] flow_ip;
		logic [15:0] flow_port;
		logic match_any_ip;
		logic match_any_port;
		logic is_system_flow;
		logic [15:0] entry_id;
	} req_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [15:0] target_id;
	} rsp_item_t;

	// Decoded request passed from the front end to the table engine.
	typedef struct packed {
		req_t kind;
		logic is_udp4;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] port;
		logic [31:0] flow_ip;
		logic [1:0] wild;
		logic sys;
		logic [15:0] entry_id;
	} cmd_t;
endpackage

/* sv/ufc_front.sv */
// Front end: accepts requests, decodes them and queues them for the table engine.
`timescale 1ns / 1ps
module ufc_front (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input ufc_pkg::req_item_t req,
	output logic cmd_valid,
	input logic cmd_take,
	output ufc_pkg::cmd_t cmd
);
	localparam int Depth = 2;
	ufc_pkg::cmd_t fifo_q [Depth];
	logic rd_ptr_q, wr_ptr_q;
	logic [1:0] count_q;
	ufc_pkg::cmd_t dec;
	logic push, pop;

	always_comb begin
		dec.kind = ufc_pkg::req_t'(req.req_type);
		dec.is_udp4 = (req.eth_type == ufc_pkg::ETH_TYPE_IPV4) &&
			(req.ip_proto == ufc_pkg::IP_PROTO_UDP);
		dec.src_ip = req.src_ip;
		dec.dst_ip = req.dst_ip;
		dec.port = (dec.kind == ufc_pkg::REQ_ADD) ? req.flow_port : req.udp_dst_port;
		dec.flow_ip = req.flow_ip;
		dec.wild = {req.match_any_port, req.match_any_ip};
		dec.sys = req.is_system_flow;
		dec.entry_id = req.entry_id;
	end

	assign req_stall = (count_q == 2'd2);
	assign push = req_valid && !req_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign pop = cmd_valid && cmd_take;
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> !pop) else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !pop) |=> count_q == 2'd2) else $error("full queue lost an item");
endmodule

/* sv/ufc_table.sv */
// Back end: flow table cells, parallel match, priority pick and compaction.
`timescale 1ns / 1ps
module ufc_table (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_take,
	input ufc_pkg::cmd_t cmd,
	output logic rsp_valid,
	input logic rsp_stall,
	output ufc_pkg::rsp_item_t rsp
);
	localparam int N = ufc_pkg::TableEntries;
	localparam int IW = ufc_pkg::IdxW;
	localparam int CW = ufc_pkg::CntW;

	logic [31:0] addr_q [N];
	logic [15:0] port_q [N];
	logic [1:0] wild_q [N];
	logic [15:0] ident_q [N];
	logic [CW-1:0] count_q;
	logic [15:0] next_id_q;
	logic def_valid_q;
	logic [15:0] def_id_q;
	logic rsp_valid_q;
	ufc_pkg::rsp_item_t rsp_q;

	logic [N-1:0] live, hit_cls, hit_dup, hit_rm;
	logic [IW-1:0] cls_idx, rm_idx;
	logic do_add, do_rm;
	ufc_pkg::rsp_item_t res;

	assign cmd_take = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			logic ip_ok;
			logic port_ok;
			live[i] = CW'(i) < count_q;
			if (wild_q[i][0]) ip_ok = 1'b1;
			else if (addr_q[i][31:28] == 4'hE) ip_ok = addr_q[i] == cmd.dst_ip;
			else ip_ok = addr_q[i] == cmd.src_ip;
			port_ok = wild_q[i][1] || (port_q[i] == cmd.port);
			hit_cls[i] = live[i] && ip_ok && port_ok;
			hit_dup[i] = live[i] && addr_q[i] == cmd.flow_ip && port_q[i] == cmd.port;
			hit_rm[i] = live[i] && ident_q[i] == cmd.entry_id;
		end
		cls_idx = '0;
		rm_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (hit_cls[i]) cls_idx = IW'(i);
			if (hit_rm[i]) rm_idx = IW'(i);
		end
	end

	always_comb begin
		do_add = 1'b0;
		do_rm = 1'b0;
		res.status = ufc_pkg::ST_OK;
		res.target_id = '0;
		unique case (cmd.kind)
			ufc_pkg::REQ_CLASSIFY: begin
				if (cmd.is_udp4 && |hit_cls) begin
					res.target_id = ident_q[cls_idx];
				end else if (def_valid_q) begin
					res.status = ufc_pkg::ST_DEFAULT;
					res.target_id = def_id_q;
				end else begin
					res.status = ufc_pkg::ST_NODEFAULT;
				end
			end
			ufc_pkg::REQ_ADD: begin
				if (|hit_dup) res.status = ufc_pkg::ST_DUP;
				else if (count_q >= CW'(N)) res.status = ufc_pkg::ST_FULL;
				else begin
					do_add = 1'b1;
					res.target_id = next_id_q;
				end
			end
			ufc_pkg::REQ_REMOVE: begin
				if (|hit_rm) begin
					do_rm = 1'b1;
					res.target_id = cmd.entry_id;
				end else begin
					res.status = ufc_pkg::ST_NOTFOUND;
				end
			end
			default: ;
		endcase
	end

	wire fire = cmd_valid && cmd_take;

	// Remove shifts every cell above the hit down by one to keep insertion order.
	always_ff @(posedge clk) begin
		if (fire && do_add) begin
			addr_q[count_q[IW-1:0]] <= cmd.flow_ip;
			port_q[count_q[IW-1:0]] <= cmd.port;
			wild_q[count_q[IW-1:0]] <= cmd.wild;
			ident_q[count_q[IW-1:0]] <= next_id_q;
		end
		if (fire && do_rm) begin
			for (int j = 0; j < N - 1; j++) begin
				if (IW'(j) >= rm_idx) begin
					addr_q[j] <= addr_q[j+1];
					port_q[j] <= port_q[j+1];
					wild_q[j] <= wild_q[j+1];
					ident_q[j] <= ident_q[j+1];
				end
			end
		end
		if (fire) rsp_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			next_id_q <= '0;
			def_valid_q <= 1'b0;
			def_id_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			if (fire && do_add) begin
				count_q <= count_q + 1'b1;
				next_id_q <= next_id_q + 16'd1;
				if (cmd.sys) begin
					def_valid_q <= 1'b1;
					def_id_q <= next_id_q;
				end
			end
			if (fire && do_rm) begin
				count_q <= count_q - 1'b1;
				if (def_id_q == cmd.entry_id) def_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(N))
		else $error("entry count above table size");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && do_add) |=> count_q == $past(count_q) + 1'b1) else $error("add lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> rsp_valid_q && $stable(rsp_q))
		else $error("held result changed");
endmodule

/* sv/udp_flow_classifier.sv */
// Top level of the UDP flow classifier: request queue front end and table back end.
// A request is first registered in the front-end queue, then its result is registered in the table back end.
// Throughput: one request per cycle while out_stall is low; the table engine resolves each request combinationally.
// A two-entry queue between front and back lets either side stall alone.
// Reset (arst_n, asynchronous) empties the table, clears the default flow and ids.
`timescale 1ns / 1ps
module udp_flow_classifier (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ufc_pkg::req_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output ufc_pkg::rsp_item_t out_data
);
	logic cmd_valid, cmd_take;
	ufc_pkg::cmd_t cmd;

	ufc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(in_valid), .req_stall(in_stall), .req(in_data),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	ufc_table u_table (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.rsp_valid(out_valid), .rsp_stall(out_stall), .rsp(out_data)
	);
endmodule
